FILE: hw/rtl/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, codes and the microcode program of the sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int RF_AW    = 3;
    localparam int RF_DEPTH = 1 << RF_AW;
    localparam int PC_W     = 7;

    typedef logic [PC_W-1:0]  pc_t;
    typedef logic [RF_AW-1:0] rf_addr_t;
    typedef logic [4:0]       src_t;

    // measurement selector
    localparam logic [1:0] OP_TEMP  = 2'd0;
    localparam logic [1:0] OP_PRESS = 2'd1;
    localparam logic [1:0] OP_HUM   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_COEFFS   = 3'd0;
    localparam logic [2:0] REG_PRESS_COEFFS_A = 3'd1;
    localparam logic [2:0] REG_PRESS_COEFFS_B = 3'd2;
    localparam logic [2:0] REG_PRESS_COEFF_NINE = 3'd3;
    localparam logic [2:0] REG_HUM_COEFFS_A  = 3'd4;
    localparam logic [2:0] REG_HUM_COEFFS_B  = 3'd5;

    // operand sources: register file entries below SRC_FIRST_EXT
    localparam src_t SRC_R0 = 5'd0;
    localparam src_t SRC_R1 = 5'd1;
    localparam src_t SRC_R2 = 5'd2;
    localparam src_t SRC_R3 = 5'd3;
    localparam src_t SRC_R4 = 5'd4;
    localparam src_t SRC_R5 = 5'd5;
    localparam src_t SRC_FIRST_EXT = 5'd8;
    localparam src_t SRC_ADC   = 5'd8;
    localparam src_t SRC_ADC16 = 5'd9;
    localparam src_t SRC_FINE  = 5'd10;
    localparam src_t SRC_T1 = 5'd11;
    localparam src_t SRC_T2 = 5'd12;
    localparam src_t SRC_T3 = 5'd13;
    localparam src_t SRC_P1 = 5'd14;
    localparam src_t SRC_P2 = 5'd15;
    localparam src_t SRC_P3 = 5'd16;
    localparam src_t SRC_P4 = 5'd17;
    localparam src_t SRC_P5 = 5'd18;
    localparam src_t SRC_P6 = 5'd19;
    localparam src_t SRC_P7 = 5'd20;
    localparam src_t SRC_P8 = 5'd21;
    localparam src_t SRC_P9 = 5'd22;
    localparam src_t SRC_H1 = 5'd23;
    localparam src_t SRC_H2 = 5'd24;
    localparam src_t SRC_H3 = 5'd25;
    localparam src_t SRC_H4 = 5'd26;
    localparam src_t SRC_H5 = 5'd27;
    localparam src_t SRC_H6 = 5'd28;
    localparam src_t SRC_IMM = 5'd29;

    localparam rf_addr_t R0 = 3'd0;
    localparam rf_addr_t R1 = 3'd1;
    localparam rf_addr_t R2 = 3'd2;
    localparam rf_addr_t R3 = 3'd3;
    localparam rf_addr_t R4 = 3'd4;
    localparam rf_addr_t R5 = 3'd5;

    // program entry points and branch targets
    localparam pc_t PC_TEMP  = 7'd0;
    localparam pc_t PC_PRESS = 7'd15;
    localparam pc_t PC_BIG   = 7'd43;
    localparam pc_t PC_JOIN  = 7'd45;
    localparam pc_t PC_DZ    = 7'd57;
    localparam pc_t PC_HUM   = 7'd58;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_RSUB, ALU_MUL, ALU_ASR,
        ALU_LSR, ALU_SHL, ALU_CLAMP, ALU_PASS, ALU_DIV
    } alu_op_t;

    typedef enum logic [1:0] {JMP_NONE, JMP_ALWAYS, JMP_NEG, JMP_ZERO} jmp_t;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC, ST_DIV} seq_state_t;

    typedef struct packed {
        alu_op_t     op;
        rf_addr_t    dst;
        src_t        src_a;
        src_t        src_b;
        logic [31:0] imm;
        logic        wr_fine;
        jmp_t        cond;
        pc_t         target;
        logic        out;
        logic        dz;
    } ucode_t;

    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        logic   div_start;
        ucode_t word;
    } dp_ctl_t;

    typedef struct packed {
        logic res_zero;
        logic res_neg;
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic load;
        logic dz;
    } seq_out_t;

    function automatic ucode_t uw(input alu_op_t op, input rf_addr_t dst,
                                  input src_t a, input src_t b, input logic [31:0] imm);
        ucode_t w;
        w.op      = op;
        w.dst     = dst;
        w.src_a   = a;
        w.src_b   = b;
        w.imm     = imm;
        w.wr_fine = 1'b0;
        w.cond    = JMP_NONE;
        w.target  = PC_TEMP;
        w.out     = 1'b0;
        w.dz      = 1'b0;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        unique case (pc)
            // temperature
            7'd0:  w = uw(ALU_LSR,  R0, SRC_ADC, SRC_IMM, 32'd3);
            7'd1:  w = uw(ALU_SHL,  R1, SRC_T1,  SRC_IMM, 32'd1);
            7'd2:  w = uw(ALU_SUB,  R0, SRC_R0,  SRC_R1,  32'd0);
            7'd3:  w = uw(ALU_MUL,  R0, SRC_R0,  SRC_T2,  32'd0);
            7'd4:  w = uw(ALU_ASR,  R0, SRC_R0,  SRC_IMM, 32'd11);
            7'd5:  w = uw(ALU_LSR,  R1, SRC_ADC, SRC_IMM, 32'd4);
            7'd6:  w = uw(ALU_SUB,  R1, SRC_R1,  SRC_T1,  32'd0);
            7'd7:  w = uw(ALU_MUL,  R1, SRC_R1,  SRC_R1,  32'd0);
            7'd8:  w = uw(ALU_ASR,  R1, SRC_R1,  SRC_IMM, 32'd12);
            7'd9:  w = uw(ALU_MUL,  R1, SRC_R1,  SRC_T3,  32'd0);
            7'd10: w = uw(ALU_ASR,  R1, SRC_R1,  SRC_IMM, 32'd14);
            7'd11: begin
                w = uw(ALU_ADD, R0, SRC_R0, SRC_R1, 32'd0);
                w.wr_fine = 1'b1;
            end
            7'd12: w = uw(ALU_MUL,  R0, SRC_R0,  SRC_IMM, 32'd5);
            7'd13: w = uw(ALU_ADD,  R0, SRC_R0,  SRC_IMM, 32'd128);
            7'd14: begin
                w = uw(ALU_ASR, R0, SRC_R0, SRC_IMM, 32'd8);
                w.out = 1'b1;
            end
            // pressure
            7'd15: w = uw(ALU_ASR,  R0, SRC_FINE, SRC_IMM, 32'd1);
            7'd16: w = uw(ALU_SUB,  R0, SRC_R0,  SRC_IMM, 32'd64000);
            7'd17: w = uw(ALU_ASR,  R1, SRC_R0,  SRC_IMM, 32'd2);
            7'd18: w = uw(ALU_MUL,  R1, SRC_R1,  SRC_R1,  32'd0);
            7'd19: w = uw(ALU_ASR,  R2, SRC_R1,  SRC_IMM, 32'd11);
            7'd20: w = uw(ALU_MUL,  R2, SRC_R2,  SRC_P6,  32'd0);
            7'd21: w = uw(ALU_MUL,  R3, SRC_R0,  SRC_P5,  32'd0);
            7'd22: w = uw(ALU_SHL,  R3, SRC_R3,  SRC_IMM, 32'd1);
            7'd23: w = uw(ALU_ADD,  R2, SRC_R2,  SRC_R3,  32'd0);
            7'd24: w = uw(ALU_ASR,  R2, SRC_R2,  SRC_IMM, 32'd2);
            7'd25: w = uw(ALU_SHL,  R3, SRC_P4,  SRC_IMM, 32'd16);
            7'd26: w = uw(ALU_ADD,  R2, SRC_R2,  SRC_R3,  32'd0);
            7'd27: w = uw(ALU_ASR,  R1, SRC_R1,  SRC_IMM, 32'd13);
            7'd28: w = uw(ALU_MUL,  R1, SRC_R1,  SRC_P3,  32'd0);
            7'd29: w = uw(ALU_ASR,  R1, SRC_R1,  SRC_IMM, 32'd3);
            7'd30: w = uw(ALU_MUL,  R3, SRC_R0,  SRC_P2,  32'd0);
            7'd31: w = uw(ALU_ASR,  R3, SRC_R3,  SRC_IMM, 32'd1);
            7'd32: w = uw(ALU_ADD,  R1, SRC_R1,  SRC_R3,  32'd0);
            7'd33: w = uw(ALU_ASR,  R1, SRC_R1,  SRC_IMM, 32'd18);
            7'd34: w = uw(ALU_ADD,  R1, SRC_R1,  SRC_IMM, 32'd32768);
            7'd35: w = uw(ALU_MUL,  R1, SRC_R1,  SRC_P1,  32'd0);
            7'd36: begin
                w = uw(ALU_ASR, R1, SRC_R1, SRC_IMM, 32'd15);
                w.cond   = JMP_ZERO;
                w.target = PC_DZ;
            end
            7'd37: w = uw(ALU_RSUB, R3, SRC_ADC, SRC_IMM, 32'd1048576);
            7'd38: w = uw(ALU_ASR,  R4, SRC_R2,  SRC_IMM, 32'd12);
            7'd39: w = uw(ALU_SUB,  R3, SRC_R3,  SRC_R4,  32'd0);
            7'd40: begin
                w = uw(ALU_MUL, R3, SRC_R3, SRC_IMM, 32'd3125);
                w.cond   = JMP_NEG;
                w.target = PC_BIG;
            end
            7'd41: w = uw(ALU_SHL,  R3, SRC_R3,  SRC_IMM, 32'd1);
            7'd42: begin
                w = uw(ALU_DIV, R3, SRC_R3, SRC_R1, 32'd0);
                w.cond   = JMP_ALWAYS;
                w.target = PC_JOIN;
            end
            7'd43: w = uw(ALU_DIV,  R3, SRC_R3,  SRC_R1,  32'd0);
            7'd44: w = uw(ALU_SHL,  R3, SRC_R3,  SRC_IMM, 32'd1);
            7'd45: w = uw(ALU_LSR,  R4, SRC_R3,  SRC_IMM, 32'd3);
            7'd46: w = uw(ALU_MUL,  R4, SRC_R4,  SRC_R4,  32'd0);
            7'd47: w = uw(ALU_LSR,  R4, SRC_R4,  SRC_IMM, 32'd13);
            7'd48: w = uw(ALU_MUL,  R4, SRC_R4,  SRC_P9,  32'd0);
            7'd49: w = uw(ALU_ASR,  R4, SRC_R4,  SRC_IMM, 32'd12);
            7'd50: w = uw(ALU_LSR,  R5, SRC_R3,  SRC_IMM, 32'd2);
            7'd51: w = uw(ALU_MUL,  R5, SRC_R5,  SRC_P8,  32'd0);
            7'd52: w = uw(ALU_ASR,  R5, SRC_R5,  SRC_IMM, 32'd13);
            7'd53: w = uw(ALU_ADD,  R4, SRC_R4,  SRC_R5,  32'd0);
            7'd54: w = uw(ALU_ADD,  R4, SRC_R4,  SRC_P7,  32'd0);
            7'd55: w = uw(ALU_ASR,  R4, SRC_R4,  SRC_IMM, 32'd4);
            7'd56: begin
                w = uw(ALU_ADD, R3, SRC_R3, SRC_R4, 32'd0);
                w.out = 1'b1;
            end
            7'd57: begin
                w = uw(ALU_PASS, R0, SRC_R0, SRC_IMM, 32'd0);
                w.out = 1'b1;
                w.dz  = 1'b1;
            end
            // humidity
            7'd58: w = uw(ALU_SUB,  R0, SRC_FINE, SRC_IMM, 32'd76800);
            7'd59: w = uw(ALU_SHL,  R1, SRC_ADC16, SRC_IMM, 32'd14);
            7'd60: w = uw(ALU_SHL,  R2, SRC_H4,  SRC_IMM, 32'd20);
            7'd61: w = uw(ALU_SUB,  R1, SRC_R1,  SRC_R2,  32'd0);
            7'd62: w = uw(ALU_MUL,  R2, SRC_H5,  SRC_R0,  32'd0);
            7'd63: w = uw(ALU_SUB,  R1, SRC_R1,  SRC_R2,  32'd0);
            7'd64: w = uw(ALU_ADD,  R1, SRC_R1,  SRC_IMM, 32'd16384);
            7'd65: w = uw(ALU_ASR,  R1, SRC_R1,  SRC_IMM, 32'd15);
            7'd66: w = uw(ALU_MUL,  R2, SRC_R0,  SRC_H6,  32'd0);
            7'd67: w = uw(ALU_ASR,  R2, SRC_R2,  SRC_IMM, 32'd10);
            7'd68: w = uw(ALU_MUL,  R3, SRC_R0,  SRC_H3,  32'd0);
            7'd69: w = uw(ALU_ASR,  R3, SRC_R3,  SRC_IMM, 32'd11);
            7'd70: w = uw(ALU_ADD,  R3, SRC_R3,  SRC_IMM, 32'd32768);
            7'd71: w = uw(ALU_MUL,  R2, SRC_R2,  SRC_R3,  32'd0);
            7'd72: w = uw(ALU_ASR,  R2, SRC_R2,  SRC_IMM, 32'd10);
            7'd73: w = uw(ALU_ADD,  R2, SRC_R2,  SRC_IMM, 32'd2097152);
            7'd74: w = uw(ALU_MUL,  R2, SRC_R2,  SRC_H2,  32'd0);
            7'd75: w = uw(ALU_ADD,  R2, SRC_R2,  SRC_IMM, 32'd8192);
            7'd76: w = uw(ALU_ASR,  R2, SRC_R2,  SRC_IMM, 32'd14);
            7'd77: w = uw(ALU_MUL,  R1, SRC_R1,  SRC_R2,  32'd0);
            7'd78: w = uw(ALU_ASR,  R2, SRC_R1,  SRC_IMM, 32'd15);
            7'd79: w = uw(ALU_MUL,  R2, SRC_R2,  SRC_R2,  32'd0);
            7'd80: w = uw(ALU_ASR,  R2, SRC_R2,  SRC_IMM, 32'd7);
            7'd81: w = uw(ALU_MUL,  R2, SRC_R2,  SRC_H1,  32'd0);
            7'd82: w = uw(ALU_ASR,  R2, SRC_R2,  SRC_IMM, 32'd4);
            7'd83: w = uw(ALU_SUB,  R1, SRC_R1,  SRC_R2,  32'd0);
            7'd84: w = uw(ALU_CLAMP, R1, SRC_R1, SRC_IMM, 32'd419430400);
            7'd85: begin
                w = uw(ALU_LSR, R1, SRC_R1, SRC_IMM, 32'd12);
                w.out = 1'b1;
            end
            default: begin
                w = uw(ALU_PASS, R0, SRC_R0, SRC_IMM, 32'd0);
                w.out = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/esc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esc_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient,
    output logic        done
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_shift;
    logic [32:0] trial;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[31]};
        trial     = rem_shift - {1'b0, div_reg};
        if (!trial[32]) begin
            rem_next = trial[31:0];
            quo_next = {quo_reg[30:0], 1'b1};
        end else begin
            rem_next = rem_shift[31:0];
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && !done_reg)
        else $error("divider did not start");

endmodule

FILE: hw/rtl/esc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_datapath
// Register file, operand latches, ALU with multiplier, divider and fine temperature.
// ----------------------------------------------------------------------------
module esc_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  esc_pkg::dp_ctl_t    ctl,
    input  logic [19:0]         adc,
    input  logic [47:0]         temp_coeffs,
    input  logic [63:0]         press_coeffs_a,
    input  logic [63:0]         press_coeffs_b,
    input  logic [15:0]         press_coeff_nine,
    input  logic [31:0]         hum_coeffs_a,
    input  logic [31:0]         hum_coeffs_b,
    output logic [31:0]         result,
    output esc_pkg::dp_status_t status
);

    logic [31:0] rf_mem [esc_pkg::RF_DEPTH];
    logic [31:0] opa_reg;
    logic [31:0] opb_reg;
    logic [31:0] fine_reg;
    logic [31:0] alu_res;
    logic [31:0] wr_data;
    logic [31:0] prod;
    logic [31:0] quo;
    logic        div_done;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] src_val(input esc_pkg::src_t s);
        logic [31:0] v;
        unique case (s)
            esc_pkg::SRC_ADC:   v = {12'd0, adc};
            esc_pkg::SRC_ADC16: v = {16'd0, adc[15:0]};
            esc_pkg::SRC_FINE:  v = fine_reg;
            esc_pkg::SRC_T1:    v = {16'd0, temp_coeffs[15:0]};
            esc_pkg::SRC_T2:    v = sx16(temp_coeffs[31:16]);
            esc_pkg::SRC_T3:    v = sx16(temp_coeffs[47:32]);
            esc_pkg::SRC_P1:    v = {16'd0, press_coeffs_a[15:0]};
            esc_pkg::SRC_P2:    v = sx16(press_coeffs_a[31:16]);
            esc_pkg::SRC_P3:    v = sx16(press_coeffs_a[47:32]);
            esc_pkg::SRC_P4:    v = sx16(press_coeffs_a[63:48]);
            esc_pkg::SRC_P5:    v = sx16(press_coeffs_b[15:0]);
            esc_pkg::SRC_P6:    v = sx16(press_coeffs_b[31:16]);
            esc_pkg::SRC_P7:    v = sx16(press_coeffs_b[47:32]);
            esc_pkg::SRC_P8:    v = sx16(press_coeffs_b[63:48]);
            esc_pkg::SRC_P9:    v = sx16(press_coeff_nine);
            esc_pkg::SRC_H1:    v = {24'd0, hum_coeffs_a[7:0]};
            esc_pkg::SRC_H2:    v = sx16(hum_coeffs_a[23:8]);
            esc_pkg::SRC_H3:    v = {24'd0, hum_coeffs_a[31:24]};
            esc_pkg::SRC_H4:    v = {{20{hum_coeffs_b[11]}}, hum_coeffs_b[11:0]};
            esc_pkg::SRC_H5:    v = {{20{hum_coeffs_b[23]}}, hum_coeffs_b[23:12]};
            esc_pkg::SRC_H6:    v = {{24{hum_coeffs_b[31]}}, hum_coeffs_b[31:24]};
            esc_pkg::SRC_IMM:   v = ctl.word.imm;
            default:            v = '0;
        endcase
        return v;
    endfunction

    // operand read: register file or coefficient/immediate source
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            if (ctl.word.src_a < esc_pkg::SRC_FIRST_EXT) begin
                opa_reg <= rf_mem[ctl.word.src_a[esc_pkg::RF_AW-1:0]];
            end else begin
                opa_reg <= src_val(ctl.word.src_a);
            end
            if (ctl.word.src_b < esc_pkg::SRC_FIRST_EXT) begin
                opb_reg <= rf_mem[ctl.word.src_b[esc_pkg::RF_AW-1:0]];
            end else begin
                opb_reg <= src_val(ctl.word.src_b);
            end
        end
    end

    // only the low word of the product is ever used
    assign prod = opa_reg * opb_reg;

    always_comb begin
        unique case (ctl.word.op)
            esc_pkg::ALU_ADD:   alu_res = opa_reg + opb_reg;
            esc_pkg::ALU_SUB:   alu_res = opa_reg - opb_reg;
            esc_pkg::ALU_RSUB:  alu_res = opb_reg - opa_reg;
            esc_pkg::ALU_MUL:   alu_res = prod;
            esc_pkg::ALU_ASR:   alu_res = 32'($signed(opa_reg) >>> opb_reg[4:0]);
            esc_pkg::ALU_LSR:   alu_res = opa_reg >> opb_reg[4:0];
            esc_pkg::ALU_SHL:   alu_res = opa_reg << opb_reg[4:0];
            esc_pkg::ALU_CLAMP: begin
                if (opa_reg[31]) begin
                    alu_res = '0;
                end else if (opa_reg > opb_reg) begin
                    alu_res = opb_reg;
                end else begin
                    alu_res = opa_reg;
                end
            end
            esc_pkg::ALU_PASS:  alu_res = opb_reg;
            default:            alu_res = '0;
        endcase
    end

    esc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start),
        .dividend (opa_reg),
        .divisor  (opb_reg),
        .quotient (quo),
        .done     (div_done)
    );

    assign wr_data = (ctl.word.op == esc_pkg::ALU_DIV) ? quo : alu_res;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            rf_mem[ctl.word.dst] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fine_reg <= '0;
        end else if (ctl.wr_en && ctl.word.wr_fine) begin
            fine_reg <= wr_data;
        end
    end

    assign result          = alu_res;
    assign status.res_zero = (alu_res == 32'd0);
    assign status.res_neg  = alu_res[31];
    assign status.div_done = div_done;

endmodule

FILE: hw/rtl/esc_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_sequencer
// Step counter over the microcode table: read, execute, divide wait, branch.
// ----------------------------------------------------------------------------
module esc_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  esc_pkg::pc_t        entry_pc,
    input  esc_pkg::dp_status_t status,
    input  logic                out_busy,
    output esc_pkg::dp_ctl_t    ctl,
    output esc_pkg::seq_out_t   seq_out,
    output logic                busy
);

    esc_pkg::seq_state_t state_reg, state_next;
    esc_pkg::pc_t        pc_reg, pc_next;
    esc_pkg::pc_t        pc_step;
    esc_pkg::ucode_t     word;
    logic                taken;
    logic                is_div;

    assign word   = esc_pkg::ucode_rom(pc_reg);
    assign is_div = (word.op == esc_pkg::ALU_DIV);

    always_comb begin
        unique case (word.cond)
            esc_pkg::JMP_NONE:   taken = 1'b0;
            esc_pkg::JMP_ALWAYS: taken = 1'b1;
            esc_pkg::JMP_NEG:    taken = status.res_neg;
            esc_pkg::JMP_ZERO:   taken = status.res_zero;
            default:             taken = 1'b0;
        endcase
        pc_step = taken ? word.target : pc_reg + esc_pkg::pc_t'(1);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            esc_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = esc_pkg::ST_READ;
                    pc_next    = entry_pc;
                end
            end
            esc_pkg::ST_READ: state_next = esc_pkg::ST_EXEC;
            esc_pkg::ST_EXEC: begin
                if (is_div) begin
                    state_next = esc_pkg::ST_DIV;
                end else if (word.out) begin
                    if (!out_busy) begin
                        state_next = esc_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = esc_pkg::ST_READ;
                    pc_next    = pc_step;
                end
            end
            esc_pkg::ST_DIV: begin
                if (status.div_done) begin
                    state_next = esc_pkg::ST_READ;
                    pc_next    = pc_step;
                end
            end
            default: state_next = esc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl.word      = word;
        ctl.rd_en     = (state_reg == esc_pkg::ST_READ);
        ctl.wr_en     = ((state_reg == esc_pkg::ST_EXEC) && !is_div && !word.out)
                     || ((state_reg == esc_pkg::ST_DIV) && status.div_done);
        ctl.div_start = (state_reg == esc_pkg::ST_EXEC) && is_div;
        seq_out.load  = (state_reg == esc_pkg::ST_EXEC) && word.out && !out_busy;
        seq_out.dz    = word.dz;
        busy          = (state_reg != esc_pkg::ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= esc_pkg::ST_IDLE;
            pc_reg    <= esc_pkg::PC_TEMP;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.div_start |=> state_reg == esc_pkg::ST_DIV)
        else $error("divide step did not wait for the divider");

    a_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        start && state_reg == esc_pkg::ST_IDLE
        |=> state_reg == esc_pkg::ST_READ && pc_reg == $past(entry_pc))
        else $error("program did not start at its entry point");

endmodule

FILE: hw/rtl/env_sensor_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation_top
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// One reading at a time: s_tready is high only while the sequencer is idle.
// Each microcode step has an operand read state and an execute state. The
// pressure divide step also waits in a divide state for the divider. A
// temperature conversion runs 15 steps, humidity 28 and pressure 40; pressure
// ends early at its divide-by-zero step when the divisor is zero. Op 3 is
// taken and dropped with no result. A finished result sits in the output
// register while the next reading is already being worked on. The sequencer
// stalls only at its final step if that register is still full. Pressure and
// humidity use the fine temperature from the last temperature conversion (zero
// after reset). The user must write coefficients through the cfg port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module env_sensor_compensation_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] raw_sample
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [31:0] temperature_centideg, [63:32] pressure_pa,
                                   // [80:64] humidity_q7_10
    output logic [2:0]  m_tuser,   // [1:0] kind, [2] divide_by_zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_coeffs_a_reg;
    logic [63:0] press_coeffs_b_reg;
    logic [15:0] press_coeff_nine_reg;
    logic [31:0] hum_coeffs_a_reg;
    logic [31:0] hum_coeffs_b_reg;

    logic [19:0] adc_reg;
    logic [1:0]  kind_reg;
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    logic                s_fire;
    logic                start;
    logic                seq_busy;
    logic                out_busy;
    logic [31:0]         result;
    esc_pkg::pc_t        entry_pc;
    esc_pkg::dp_ctl_t    ctl;
    esc_pkg::dp_status_t status;
    esc_pkg::seq_out_t   seq_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg      <= '0;
            press_coeffs_a_reg   <= '0;
            press_coeffs_b_reg   <= '0;
            press_coeff_nine_reg <= '0;
            hum_coeffs_a_reg     <= '0;
            hum_coeffs_b_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                esc_pkg::REG_TEMP_COEFFS:      temp_coeffs_reg      <= cfg_data[47:0];
                esc_pkg::REG_PRESS_COEFFS_A:   press_coeffs_a_reg   <= cfg_data;
                esc_pkg::REG_PRESS_COEFFS_B:   press_coeffs_b_reg   <= cfg_data;
                esc_pkg::REG_PRESS_COEFF_NINE: press_coeff_nine_reg <= cfg_data[15:0];
                esc_pkg::REG_HUM_COEFFS_A:     hum_coeffs_a_reg     <= cfg_data[31:0];
                esc_pkg::REG_HUM_COEFFS_B:     hum_coeffs_b_reg     <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !seq_busy;
    assign s_fire   = s_tvalid && s_tready;
    assign start    = s_fire && (s_tuser != esc_pkg::OP_NONE);

    always_comb begin
        unique case (s_tuser)
            esc_pkg::OP_PRESS: entry_pc = esc_pkg::PC_PRESS;
            esc_pkg::OP_HUM:   entry_pc = esc_pkg::PC_HUM;
            default:           entry_pc = esc_pkg::PC_TEMP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            adc_reg  <= s_tdata[19:0];
            kind_reg <= s_tuser;
        end
    end

    esc_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .entry_pc (entry_pc),
        .status   (status),
        .out_busy (out_busy),
        .ctl      (ctl),
        .seq_out  (seq_out),
        .busy     (seq_busy)
    );

    esc_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .adc              (adc_reg),
        .temp_coeffs      (temp_coeffs_reg),
        .press_coeffs_a   (press_coeffs_a_reg),
        .press_coeffs_b   (press_coeffs_b_reg),
        .press_coeff_nine (press_coeff_nine_reg),
        .hum_coeffs_a     (hum_coeffs_a_reg),
        .hum_coeffs_b     (hum_coeffs_b_reg),
        .result           (result),
        .status           (status)
    );

    // output register
    assign out_busy = m_tvalid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (seq_out.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_out.load) begin
            m_tdata_reg <= {7'd0,
                            (kind_reg == esc_pkg::OP_HUM) ? result[16:0] : 17'd0,
                            (kind_reg == esc_pkg::OP_PRESS) ? result : 32'd0,
                            (kind_reg == esc_pkg::OP_TEMP) ? result : 32'd0};
            m_tuser_reg <= {seq_out.dz, kind_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_out.load |=> m_tvalid_reg)
        else $error("result load did not raise m_tvalid");

    a_dz_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[2] |-> m_tuser_reg[1:0] == esc_pkg::OP_PRESS)
        else $error("divide flag on a non-pressure result");

endmodule
